/* sv/sgrpm_pkg.sv */
package sgrpm_pkg;

    // sample and gain formats
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 15;
    localparam int GAIN_BITS      = 16;
    localparam int STEP_BITS      = 9;
    localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS;
    localparam int ROUND_BITS     = PROD_BITS - GAIN_FRAC_BITS;

    localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(64'd1 << GAIN_FRAC_BITS);
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(68);
    localparam logic [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(64'd1 << (GAIN_FRAC_BITS - 1));

    localparam logic [SAMPLE_BITS-1:0] NEG_LIMIT = SAMPLE_BITS'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] POS_LIMIT = NEG_LIMIT - SAMPLE_BITS'(1);

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam cfg_index_t REG_TARGET_GAIN = 1'b0;
    localparam cfg_index_t REG_RAMP_STEP   = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          left_not_finite;
        logic                          right_not_finite;
        logic                          buffer_last;
    } frame_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic        [SAMPLE_BITS-1:0] input_peak_level;
        logic        [SAMPLE_BITS-1:0] output_peak_level;
        logic                          buffer_done;
    } frame_out_t;

    // one scaled channel with the magnitudes the meter needs
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic        [SAMPLE_BITS-1:0] in_mag;
        logic        [SAMPLE_BITS-1:0] out_mag;
    } scale_t;

endpackage

/* sv/sgrpm_scale.sv */
module sgrpm_scale (
    input  logic signed [sgrpm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                     not_finite,
    input  logic        [sgrpm_pkg::GAIN_BITS-1:0]   gain,
    output sgrpm_pkg::scale_t                        result
);
    import sgrpm_pkg::*;

    logic                   raw_neg;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [PROD_BITS-1:0]   prod;
    logic [ROUND_BITS-1:0]  rounded;
    logic [SAMPLE_BITS-1:0] sat;

    always_comb
    begin
        raw     = sample;
        raw_neg = raw[SAMPLE_BITS-1];
        neg     = raw_neg && !not_finite;
        // non-finite source reads as zero
        if (not_finite)
        begin
            mag = '0;
        end
        else if (raw_neg)
        begin
            mag = ~raw + SAMPLE_BITS'(1);
        end
        else
        begin
            mag = raw;
        end

        // magnitude times gain, round half away from zero
        prod    = PROD_BITS'(mag) * PROD_BITS'(gain) + ROUND_HALF;
        rounded = prod[PROD_BITS-1:GAIN_FRAC_BITS];

        if (neg)
        begin
            sat = (rounded > ROUND_BITS'(NEG_LIMIT)) ? NEG_LIMIT : rounded[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = (rounded > ROUND_BITS'(POS_LIMIT)) ? POS_LIMIT : rounded[SAMPLE_BITS-1:0];
        end

        result.sample_out = neg ? (~sat + SAMPLE_BITS'(1)) : sat;
        result.in_mag     = mag;
        result.out_mag    = sat;
    end

endmodule

/* sv/sgrpm_gain_ramp.sv */
module sgrpm_gain_ramp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  sgrpm_pkg::cfg_index_t             cfg_index,
    input  sgrpm_pkg::cfg_data_t              cfg_data,
    input  logic                              advance,
    output logic [sgrpm_pkg::GAIN_BITS-1:0]   gain_next
);
    import sgrpm_pkg::*;

    logic [GAIN_BITS-1:0] target_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [GAIN_BITS-1:0] current_gain_reg;
    logic [GAIN_BITS-1:0] target_clamped;
    logic [GAIN_BITS-1:0] step_wide;
    logic [GAIN_BITS-1:0] diff;

    always_comb
    begin
        target_clamped = (target_reg > UNITY_GAIN) ? UNITY_GAIN : target_reg;
        step_wide      = GAIN_BITS'(step_reg);
        if (target_clamped >= current_gain_reg)
        begin
            diff      = target_clamped - current_gain_reg;
            gain_next = current_gain_reg + ((diff > step_wide) ? step_wide : diff);
        end
        else
        begin
            diff      = current_gain_reg - target_clamped;
            gain_next = current_gain_reg - ((diff > step_wide) ? step_wide : diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= UNITY_GAIN;
            step_reg         <= STEP_RESET;
            current_gain_reg <= UNITY_GAIN;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TARGET_GAIN: target_reg <= cfg_data[GAIN_BITS-1:0];
                    REG_RAMP_STEP:   step_reg   <= cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            if (advance)
            begin
                current_gain_reg <= gain_next;
            end
        end
    end

    a_gain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        current_gain_reg <= UNITY_GAIN)
        else $error("gain left the range 0 to unity");

endmodule

/* sv/sgrpm_peak_meter.sv */
module sgrpm_peak_meter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                update,
    input  logic                                last,
    input  sgrpm_pkg::scale_t                   left,
    input  sgrpm_pkg::scale_t                   right,
    output logic [sgrpm_pkg::SAMPLE_BITS-1:0]   input_peak,
    output logic [sgrpm_pkg::SAMPLE_BITS-1:0]   output_peak
);
    import sgrpm_pkg::*;

    logic [SAMPLE_BITS-1:0] in_peak_reg;
    logic [SAMPLE_BITS-1:0] out_peak_reg;
    logic [SAMPLE_BITS-1:0] in_max;
    logic [SAMPLE_BITS-1:0] out_max;

    always_comb
    begin
        in_max      = (left.in_mag > right.in_mag) ? left.in_mag : right.in_mag;
        out_max     = (left.out_mag > right.out_mag) ? left.out_mag : right.out_mag;
        input_peak  = (in_max > in_peak_reg) ? in_max : in_peak_reg;
        output_peak = (out_max > out_peak_reg) ? out_max : out_peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_peak_reg  <= '0;
            out_peak_reg <= '0;
        end
        else if (update)
        begin
            // clear after the last frame of a buffer
            in_peak_reg  <= last ? '0 : input_peak;
            out_peak_reg <= last ? '0 : output_peak;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        update && last |=> in_peak_reg == '0 && out_peak_reg == '0)
        else $error("peaks not cleared after last frame");

endmodule

/* sv/stereo_gain_ramp_peak_meter_unit.sv */
// channel  | dir | handshake          | beat
// ---------+-----+--------------------+-----------------------------------------
// in       | in  | in_valid/in_stall  | one stereo frame (frame_in_t)
// out      | out | out_valid/out_stall| scaled frame with running peaks
// cfg      | in  | cfg_valid/cfg_ready| register index and write data
//
// frames pass the input and result registers; one frame per cycle unless out stalls
// the gain ramp (one add and compare) runs as a frame enters the input register,
// the 24x16 multiply, rounding, saturation and peak update run into the result register
// rst_n clears valids, configuration (target unity, step 68), gain and peaks
// an out stall holds the result register; the input register drains into it when free,
// so in_stall rises only while both registers are full and out is stalled
module stereo_gain_ramp_peak_meter_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sgrpm_pkg::frame_in_t   in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sgrpm_pkg::frame_out_t  out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  sgrpm_pkg::cfg_index_t  cfg_index,
    input  sgrpm_pkg::cfg_data_t   cfg_data
);
    import sgrpm_pkg::*;

    // input register with the gain this frame uses
    logic                   s1_valid_reg;
    frame_in_t              s1_frame_reg;
    logic [GAIN_BITS-1:0]   s1_gain_reg;

    // result register
    logic                   out_valid_reg;
    frame_out_t             out_data_reg;
    frame_out_t             out_data_next;

    logic                   in_accept;
    logic                   s1_advance;
    logic                   s1_move;
    logic [GAIN_BITS-1:0]   gain_next;
    scale_t                 left_scaled;
    scale_t                 right_scaled;
    logic [SAMPLE_BITS-1:0] input_peak;
    logic [SAMPLE_BITS-1:0] output_peak;

    // config is always taken
    assign cfg_ready = 1'b1;

    // result register free or being drained this cycle
    assign s1_advance = !out_valid_reg || !out_stall;
    assign s1_move    = s1_advance && s1_valid_reg;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // gain moves toward the target once per accepted frame
    sgrpm_gain_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_accept),
        .gain_next (gain_next)
    );

    sgrpm_scale u_scale_left (
        .sample     (s1_frame_reg.left_sample),
        .not_finite (s1_frame_reg.left_not_finite),
        .gain       (s1_gain_reg),
        .result     (left_scaled)
    );

    sgrpm_scale u_scale_right (
        .sample     (s1_frame_reg.right_sample),
        .not_finite (s1_frame_reg.right_not_finite),
        .gain       (s1_gain_reg),
        .result     (right_scaled)
    );

    // peaks include the frame moving into the result register
    sgrpm_peak_meter u_meter (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (s1_move),
        .last        (s1_frame_reg.buffer_last),
        .left        (left_scaled),
        .right       (right_scaled),
        .input_peak  (input_peak),
        .output_peak (output_peak)
    );

    always_comb
    begin
        out_data_next.left_out          = left_scaled.sample_out;
        out_data_next.right_out         = right_scaled.sample_out;
        out_data_next.input_peak_level  = input_peak;
        out_data_next.output_peak_level = output_peak;
        out_data_next.buffer_done       = s1_frame_reg.buffer_last;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_frame_reg <= in_data;
            s1_gain_reg  <= gain_next;
        end
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a stalled input means a full input register
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

    // gain never exceeds unity, so output magnitude never passes input magnitude
    a_out_peak_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.output_peak_level <= out_data.input_peak_level)
        else $error("output peak above input peak");

    // a frame held in the input register is not dropped
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_frame_reg))
        else $error("held frame lost from input register");

endmodule
